FILE: rtl/core/dual_quadrature_odometry_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dual quadrature odometry block
// Clocked on clk and disabled during rst in every module that uses them.
// ---------------------------------------------------------------------------
`ifndef DUAL_QUADRATURE_ODOMETRY_MACROS_SVH
`define DUAL_QUADRATURE_ODOMETRY_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define DQO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define DQO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dqo_pkg.sv
// ---------------------------------------------------------------------------
// dqo_pkg
// Shared widths, step decoding and control types for the odometry block.
// ---------------------------------------------------------------------------
package dqo_pkg;

  localparam int COUNT_WIDTH = 16;   // running encoder count
  localparam int ACCUM_WIDTH = 32;   // position and side accumulators
  localparam int PIN_WIDTH   = 2;    // A in bit0, B in bit1
  localparam int SPEED_WIDTH = 16;   // speed result fields
  localparam int TRACK_WIDTH = 32;   // accumulator result fields

  localparam int IN_DATA_WIDTH  = ((2 * PIN_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = 2 * SPEED_WIDTH + 2 * TRACK_WIDTH;

  typedef enum logic [1:0] {
    STEP_NONE = 2'b00,
    STEP_UP   = 2'b01,
    STEP_DOWN = 2'b10
  } step_t;

  // Control that moves one request from the input register into the state.
  typedef struct packed {
    logic advance;  // input register hands its request on this cycle
    logic tick;     // the request carries a read tick
  } step_ctrl_t;

  // Gray-code transition table: previous state against current state.
  // A jump of both bits, or no change, gives no step.
  function automatic step_t step_decode(input logic [PIN_WIDTH-1:0] last,
                                        input logic [PIN_WIDTH-1:0] now);
    step_t s;
    s = STEP_NONE;
    unique case ({last, now})
      4'b00_01: s = STEP_DOWN;
      4'b00_10: s = STEP_UP;
      4'b01_00: s = STEP_UP;
      4'b01_11: s = STEP_DOWN;
      4'b10_00: s = STEP_DOWN;
      4'b10_11: s = STEP_UP;
      4'b11_01: s = STEP_UP;
      4'b11_10: s = STEP_DOWN;
      default:  s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/dqo_encoder.sv
// ---------------------------------------------------------------------------
// dqo_encoder
// One quadrature channel: last pin state and wrapping up/down count.
// ---------------------------------------------------------------------------
`include "dual_quadrature_odometry_macros.svh"

module dqo_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  dqo_pkg::step_ctrl_t           ctrl,
  input  logic [dqo_pkg::PIN_WIDTH-1:0] pins,
  output logic [dqo_pkg::COUNT_WIDTH-1:0] count_upd
);
  import dqo_pkg::*;

  logic [PIN_WIDTH-1:0]   last_pins;
  logic [COUNT_WIDTH-1:0] count;
  step_t                  step;

  assign step = step_decode(last_pins, pins);

  always_comb begin
    unique case (step)
      STEP_UP:   count_upd = count + COUNT_WIDTH'(1);
      STEP_DOWN: count_upd = count - COUNT_WIDTH'(1);
      default:   count_upd = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pins <= '0;
      count     <= '0;
    end else if (ctrl.advance) begin
      last_pins <= pins;
      count     <= ctrl.tick ? '0 : count_upd;
    end
  end

  `DQO_ASSERT_NEXT(a_tick_clears, ctrl.advance && ctrl.tick, count == '0, "count not cleared by tick")
  `DQO_ASSERT_NEXT(a_idle_holds, !ctrl.advance, $stable(count) && $stable(last_pins), "encoder state moved while idle")
  `DQO_ASSERT_NOW(a_single_step, 1'b1, (count_upd - count == COUNT_WIDTH'(0)) || (count_upd - count == COUNT_WIDTH'(1)) || (count - count_upd == COUNT_WIDTH'(1)), "count moved by more than one")

endmodule

FILE: rtl/core/dqo_accum.sv
// ---------------------------------------------------------------------------
// dqo_accum
// Speed snapshot, position and side accumulators, and the result register.
// ---------------------------------------------------------------------------
`include "dual_quadrature_odometry_macros.svh"

module dqo_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  dqo_pkg::step_ctrl_t                ctrl,
  input  logic [dqo_pkg::COUNT_WIDTH-1:0]    right_count,
  input  logic [dqo_pkg::COUNT_WIDTH-1:0]    left_count,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dqo_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);
  import dqo_pkg::*;

  logic signed [COUNT_WIDTH-1:0] rs;
  logic signed [COUNT_WIDTH-1:0] ls;
  logic [ACCUM_WIDTH-1:0]        position_sum;
  logic [ACCUM_WIDTH-1:0]        side_sum;
  logic [ACCUM_WIDTH-1:0]        position_sum_next;
  logic [ACCUM_WIDTH-1:0]        side_sum_next;
  logic                          out_valid;
  logic [OUT_DATA_WIDTH-1:0]     out_data;
  logic                          load;

  // Right wheel is mounted mirrored: report its count negated.
  assign rs = $signed(COUNT_WIDTH'(0) - right_count);
  assign ls = $signed(left_count);

  assign position_sum_next = position_sum + ACCUM_WIDTH'(rs) + ACCUM_WIDTH'(ls);
  assign side_sum_next     = side_sum + ACCUM_WIDTH'(rs) - ACCUM_WIDTH'(ls);

  assign load = ctrl.advance && ctrl.tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_sum <= '0;
      side_sum     <= '0;
      out_valid    <= 1'b0;
    end else if (load) begin
      position_sum <= position_sum_next;
      side_sum     <= side_sum_next;
      out_valid    <= 1'b1;
    end else if (m_tready) begin
      out_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {TRACK_WIDTH'($signed(side_sum_next)),
                   TRACK_WIDTH'($signed(position_sum_next)),
                   SPEED_WIDTH'(ls),
                   SPEED_WIDTH'(rs)};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  `DQO_ASSERT_NOW(a_no_overwrite, load, !out_valid || m_tready, "result overwritten before taken")
  `DQO_ASSERT_NEXT(a_load_shows, load, m_tvalid, "result not presented after tick")
  `DQO_ASSERT_NEXT(a_sums_hold, !load, $stable(position_sum) && $stable(side_sum), "accumulator moved without tick")

endmodule

FILE: rtl/core/dual_quadrature_odometry.sv
// ---------------------------------------------------------------------------
// dual_quadrature_odometry
// Two-wheel quadrature decoder with speed snapshot and odometry sums.
// ---------------------------------------------------------------------------
// Each accepted request samples the right and left encoder A/B pins and steps
// each 16-bit wrapping count by -1, 0 or +1 per the Gray-code transition (a
// jump of both pins counts nothing). A request with the read tick set first
// applies its own pin sample, then emits one result: the negated right count,
// the left count, and the 32-bit wrapping position (sum of both speeds) and
// side difference (right minus left) accumulators after this update; both
// counts restart from zero. Requests without a tick emit nothing. The block
// takes one request per clock while no tick request waits: a request is held
// in the input register, the decode and the accumulator adds run from there,
// and the result is registered in the output register. Only a tick request
// whose result would overwrite an untaken result waits in the input register;
// pin samples keep streaming otherwise.
// ---------------------------------------------------------------------------
`include "dual_quadrature_odometry_macros.svh"

module dual_quadrature_odometry (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata: [1:0] right_pins, [3:2] left_pins, [7:4] zero
  input  logic [dqo_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
  // s_tuser: [0] read_tick
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata: [15:0] right_speed, [31:16] left_speed,
  //          [63:32] position, [95:64] side_difference
  output logic [dqo_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);
  import dqo_pkg::*;

  // Input register: holds one request ahead of the decode logic.
  logic                   in_valid;
  logic [PIN_WIDTH-1:0]   in_right;
  logic [PIN_WIDTH-1:0]   in_left;
  logic                   in_tick;
  logic                   advance;
  step_ctrl_t             ctrl;
  logic [COUNT_WIDTH-1:0] right_count;
  logic [COUNT_WIDTH-1:0] left_count;

  // Advance unless a tick would clobber a result still waiting downstream.
  assign advance  = in_valid && (!in_tick || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  assign ctrl.advance = advance;
  assign ctrl.tick    = in_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_right <= s_tdata[PIN_WIDTH-1:0];
      in_left  <= s_tdata[2*PIN_WIDTH-1:PIN_WIDTH];
      in_tick  <= s_tuser;
    end
  end

  dqo_encoder u_right (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .pins      (in_right),
    .count_upd (right_count)
  );

  dqo_encoder u_left (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .pins      (in_left),
    .count_upd (left_count)
  );

  dqo_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .right_count (right_count),
    .left_count  (left_count),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  // A request only waits when it is a tick blocked by an untaken result.
  `DQO_ASSERT_NOW(a_stall_reason, in_valid && !advance, in_tick && m_tvalid && !m_tready, "input stalled without cause")
  `DQO_ASSERT_NOW(a_plain_flows, in_valid && !in_tick, advance, "pin sample failed to advance")
  `DQO_ASSERT_NEXT(a_result_source, !(advance && in_tick) && !m_tvalid, !m_tvalid, "result appeared without a tick")

endmodule
